@@ rtl/core/stpd_pkg.sv @@
// Shared types and constants for the slot table dispatcher.
// Used by stpd_ctrl, stpd_datapath and slot_table_min_priority_dispatch.
package stpd_pkg;

  localparam int SLOTS_DEF     = 10;
  localparam int TAG_WIDTH_DEF = 32;

  localparam int PRIO_W     = 4;
  localparam int IN_TAG_W   = 32;
  localparam int OUT_TAG_W  = 32;
  localparam int IN_DATA_W  = 40;  // priority + tag, padded to whole bytes
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  localparam logic [PRIO_W-1:0] LIMIT_RESET = 4'd9;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_TICK_READ,
    ST_TICK_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;      // latch the item, rewind the slot counter
    logic ins_step;  // test one slot for space, store there if free
    logic rd_step;   // read one slot for the minimum search
    logic finish;    // load the result register, free the picked slot on a tick
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic slot_free;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/stpd_ctrl.sv @@
// Sequencer for the slot table dispatcher.
// Depends on stpd_pkg for the state, command and status types.
module stpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  stpd_pkg::op_t     s_op,
  output stpd_pkg::cmd_t    cmd,
  input  stpd_pkg::status_t status
);
  import stpd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_valid) begin
          state_next = (s_op == OP_TICK) ? ST_TICK_READ : ST_INS_SCAN;
        end
      end
      ST_INS_SCAN: begin
        if (status.slot_free || status.idx_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_TICK_READ: begin
        if (status.idx_last) begin
          state_next = ST_TICK_DRAIN;
        end
      end
      ST_TICK_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready = 1'b0;
    cmd     = '0;
    case (state)
      ST_IDLE: begin
        s_ready  = 1'b1;
        cmd.load = s_valid;
      end
      ST_INS_SCAN: begin
        cmd.ins_step = 1'b1;
      end
      ST_TICK_READ: begin
        cmd.rd_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/stpd_datapath.sv @@
// Slot table, minimum search, limit register and result register.
// Depends on stpd_pkg; driven by stpd_ctrl through cmd_t and status_t.
module stpd_datapath #(
  parameter int SLOTS     = stpd_pkg::SLOTS_DEF,
  parameter int TAG_WIDTH = stpd_pkg::TAG_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  stpd_pkg::cmd_t                  cmd,
  output stpd_pkg::status_t               status,
  input  stpd_pkg::op_t                   in_op,
  input  logic [stpd_pkg::PRIO_W-1:0]     in_prio,
  input  logic [stpd_pkg::IN_TAG_W-1:0]   in_tag,
  input  logic                            cfg_we,
  input  logic [stpd_pkg::PRIO_W-1:0]     cfg_limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic                            out_dispatched,
  output logic [stpd_pkg::PRIO_W-1:0]     out_prio,
  output logic [stpd_pkg::OUT_TAG_W-1:0]  out_tag
);
  import stpd_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

  logic [PRIO_W-1:0]    limit;
  logic [SLOTS-1:0]     valid;
  logic [PRIO_W-1:0]    prio_mem [SLOTS];
  logic [TAG_WIDTH-1:0] tag_mem  [SLOTS];

  op_t                  item_op;
  logic [PRIO_W-1:0]    item_prio;
  logic [TAG_WIDTH-1:0] item_tag;
  logic [IDX_W-1:0]     idx;

  logic                 rd_pend;
  logic                 rd_ok;
  logic [IDX_W-1:0]     rd_idx;
  logic [PRIO_W-1:0]    rd_prio;
  logic [TAG_WIDTH-1:0] rd_tag;

  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [PRIO_W-1:0]    best;
  logic [TAG_WIDTH-1:0] best_tag;

  logic [TAG_WIDTH+IN_TAG_W-1:0]  in_tag_ext;
  logic [TAG_WIDTH+OUT_TAG_W-1:0] best_tag_ext;
  logic                           slot_free;
  logic                           better;

  assign in_tag_ext   = {{TAG_WIDTH{1'b0}}, in_tag};
  assign best_tag_ext = {{OUT_TAG_W{1'b0}}, best_tag};
  assign slot_free    = ~valid[idx];
  assign better       = rd_pend && rd_ok && (rd_prio < best);

  assign status.idx_last  = (idx == IDX_LAST);
  assign status.slot_free = slot_free;
  assign status.out_free  = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_limit;
    end
  end

  // Slot memories: one write port for inserts, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.ins_step && slot_free) begin
      prio_mem[idx] <= item_prio;
      tag_mem[idx]  <= item_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      rd_prio <= prio_mem[idx];
      rd_tag  <= tag_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.ins_step && slot_free) begin
      valid[idx] <= 1'b1;
    end else if (cmd.finish && item_op == OP_TICK && found) begin
      valid[pick] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step) begin
      rd_ok  <= valid[idx];
      rd_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= in_op;
      item_prio <= in_prio;
      item_tag  <= in_tag_ext[TAG_WIDTH-1:0];
      idx       <= '0;
      best      <= limit;
      found     <= 1'b0;
    end else begin
      if (cmd.ins_step || cmd.rd_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.ins_step && slot_free) begin
        found <= 1'b1;
      end
      if (better) begin
        best     <= rd_prio;
        best_tag <= rd_tag;
        pick     <= rd_idx;
        found    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (item_op == OP_TICK) begin
        out_accepted   <= 1'b0;
        out_dispatched <= found;
        out_prio       <= found ? best : '0;
        out_tag        <= found ? best_tag_ext[OUT_TAG_W-1:0] : '0;
      end else begin
        out_accepted   <= found;
        out_dispatched <= 1'b0;
        out_prio       <= '0;
        out_tag        <= '0;
      end
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.ins_step, cmd.rd_step, cmd.finish}))
    else $error("more than one datapath command at once");

  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_step && slot_free |=> valid[$past(idx)])
    else $error("stored slot not marked occupied");

  a_dispatch_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.finish && item_op == OP_TICK && found |=> !valid[$past(pick)])
    else $error("dispatched slot still occupied");

endmodule

@@ rtl/core/slot_table_min_priority_dispatch.sv @@
// Top level of the slot table minimum-priority dispatcher.
// Depends on stpd_pkg, stpd_ctrl and stpd_datapath.
//
//  channel  | direction | signals                               | content
//  ---------+-----------+---------------------------------------+-----------------------------
//  s_axis   | in        | tvalid tready tdata[39:0] tuser[0]    | insert request or tick
//  m_axis   | out       | tvalid tready tdata[39:0] tuser[1:0]  | one result per transaction
//  cfg      | in        | valid ready data[3:0]                 | dispatch limit register
//
// An insert walks the valid bits one slot a cycle from slot 0 and stops at the first
// free one, or at the last slot when none is free; then the result register is loaded.
// A tick reads one slot a cycle through the registered memory port and keeps a running
// minimum, then drains the last read and loads the result register.
// Reset clears all valid bits at once and sets the limit to 9; no clearing pass.
// A stalled result holds in the output register; the next item is taken meanwhile and
// waits at its end until that register is free.
module slot_table_min_priority_dispatch #(
  parameter int SLOTS     = stpd_pkg::SLOTS_DEF,
  parameter int TAG_WIDTH = stpd_pkg::TAG_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata: req_priority[3:0], req_tag[35:4], zero padding[39:36]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [stpd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // s_axis_tuser: opcode[0]
  input  logic [0:0]                          s_axis_tuser,
  // m_axis_tdata: out_priority[3:0], out_tag[35:4], zero padding[39:36]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [stpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // m_axis_tuser: accepted[0], dispatched[1]
  output logic [stpd_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stpd_pkg::PRIO_W-1:0]         cfg_data
);
  import stpd_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  op_t                  in_op;
  logic                 out_accepted;
  logic                 out_dispatched;
  logic [PRIO_W-1:0]    out_prio;
  logic [OUT_TAG_W-1:0] out_tag;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  assign in_op = op_t'(s_axis_tuser[0]);

  // Pack the result transaction, zero padding in the top nibble.
  assign m_axis_tdata = {{(OUT_DATA_W - PRIO_W - OUT_TAG_W){1'b0}}, out_tag, out_prio};
  assign m_axis_tuser = {out_dispatched, out_accepted};

  stpd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_op    (in_op),
    .cmd     (cmd),
    .status  (status)
  );

  stpd_datapath #(
    .SLOTS     (SLOTS),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .in_op          (in_op),
    .in_prio        (s_axis_tdata[PRIO_W-1:0]),
    .in_tag         (s_axis_tdata[PRIO_W+IN_TAG_W-1:PRIO_W]),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_limit      (cfg_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_accepted   (out_accepted),
    .out_dispatched (out_dispatched),
    .out_prio       (out_prio),
    .out_tag        (out_tag)
  );

endmodule
